/* hdl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg: shared types and helpers for the splitter tree classifier
// Holds the tree size, the item codes, the per-level stage record and the
// bucket arithmetic used by the cells and by the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

  // Number of tree levels; the tree holds 2^TREE_BITS - 1 splitters.
  localparam int TREE_BITS     = 4;
  localparam int NUM_SPLITTERS = (1 << TREE_BITS) - 1;

  // Fixed field widths of the channels.
  localparam int KEY_W    = 64;
  localparam int NIDX_W   = 4;
  localparam int BUCKET_W = 5;

  // Heap index of the current node, one bit more than a level needs so that
  // a leaf slot below the last level still fits.
  localparam int NODE_W     = TREE_BITS + 1;
  localparam int LEVEL_W    = (TREE_BITS > 1) ? $clog2(TREE_BITS) : 1;
  localparam int LOCAL_BITS = (TREE_BITS > 1) ? TREE_BITS - 1 : 1;
  localparam int LOCAL_DEPTH = 1 << LOCAL_BITS;
  localparam int IDX_W      = (NODE_W > NIDX_W) ? NODE_W : NIDX_W;
  localparam int CALC_W     = (TREE_BITS + 2 > BUCKET_W) ? TREE_BITS + 2 : BUCKET_W;

  typedef enum logic {
    FUNC_LOAD     = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } func_t;

  // One item as it travels down the chain of cells.
  typedef struct packed {
    logic                valid;
    func_t               func;
    logic [NIDX_W-1:0]   node_index;
    logic [KEY_W-1:0]    key;
    logic [NODE_W-1:0]   node;
    logic                hit;
    logic [BUCKET_W-1:0] bucket;
  } stage_t;

  // Odd bucket for a key equal to the splitter at a node of a given level.
  function automatic logic [BUCKET_W-1:0] hit_bucket(logic [NODE_W-1:0] node,
                                                     logic [LEVEL_W-1:0] level);
    logic [CALC_W-1:0] shifted;
    logic [CALC_W-1:0] pos;
    logic [CALC_W-1:0] b;
    shifted = CALC_W'(node) << (TREE_BITS - int'(level));
    pos = (shifted & CALC_W'(NUM_SPLITTERS)) |
          (CALC_W'(1) << (TREE_BITS - 1 - int'(level)));
    b = (pos << 1) - CALC_W'(1);
    return b[BUCKET_W-1:0];
  endfunction

  // Even bucket for a key that fell off the tree below the last level.
  function automatic logic [BUCKET_W-1:0] leaf_bucket(logic [NODE_W-1:0] node);
    logic [CALC_W-1:0] b;
    b = CALC_W'(node[TREE_BITS-1:0]) << 1;
    return b[BUCKET_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/stc_in_if.sv */
// ----------------------------------------------------------------------------
// stc_in_if: input channel of the splitter tree classifier
// Carries one load or classify item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface stc_in_if;
  import stc_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [NIDX_W-1:0] node_index;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output func, output node_index, output key,
                  input ready);
  modport sink   (input valid, input func, input node_index, input key,
                  output ready);
endinterface

`default_nettype wire

/* hdl/stc_out_if.sv */
// ----------------------------------------------------------------------------
// stc_out_if: result channel of the splitter tree classifier
// Carries one bucket number with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface stc_out_if;
  import stc_pkg::*;

  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket;

  modport source (output valid, output bucket, input ready);
  modport sink   (input valid, input bucket, output ready);
endinterface

`default_nettype wire

/* hdl/stc_cell.sv */
// ----------------------------------------------------------------------------
// stc_cell: one tree level of the classifier chain
// Holds the splitters of its level, writes them for load items and steps a
// classify item one node down or marks a hit, passing it to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [stc_pkg::LEVEL_W-1:0]  level,
  input  wire logic                         advance,
  input  wire stc_pkg::stage_t              cur,
  output stc_pkg::stage_t                   nxt
);
  import stc_pkg::*;

  logic [KEY_W-1:0]      store [LOCAL_DEPTH];
  logic [NODE_W-1:0]     node_mask;
  logic [LOCAL_BITS-1:0] rd_off;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      idx_mask;
  logic [LOCAL_BITS-1:0] wr_off;
  logic                  wr_en;
  logic [KEY_W-1:0]      splitter;
  stage_t                nxt_next;

  // Nodes of this level have bit "level" set; the bits below it pick the entry.
  always_comb begin
    node_mask = (NODE_W'(1) << level) - NODE_W'(1);
    rd_off    = LOCAL_BITS'(cur.node & node_mask);
    idx       = IDX_W'(cur.node_index);
    idx_mask  = (IDX_W'(1) << level) - IDX_W'(1);
    wr_off    = LOCAL_BITS'(idx & idx_mask);
    wr_en     = advance && cur.valid && (cur.func == FUNC_LOAD) &&
                ((idx >> level) == IDX_W'(1));
    splitter  = store[rd_off];
  end

  always_comb begin
    nxt_next = cur;
    if (cur.valid && (cur.func == FUNC_CLASSIFY) && !cur.hit) begin
      if (cur.key == splitter) begin
        nxt_next.hit    = 1'b1;
        nxt_next.bucket = hit_bucket(cur.node, level);
      end else begin
        nxt_next.node = {cur.node[NODE_W-2:0], (cur.key > splitter)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_off] <= cur.key;
    end
  end

  // Only the valid bit is cleared by reset; the payload follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      nxt.valid <= 1'b0;
    end else if (advance) begin
      nxt <= nxt_next;
    end
  end

`ifndef ASSERT_OFF
  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    !rst && advance && cur.valid |=> nxt.valid)
    else $error("item lost between cells");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !rst && !advance |=> nxt.valid == $past(nxt.valid))
    else $error("cell changed while the chain was stalled");

  a_hit_kept: assert property (@(posedge clk) disable iff (rst)
    !rst && advance && cur.valid && cur.hit |=>
      nxt.hit && (nxt.bucket == $past(cur.bucket)))
    else $error("matched bucket changed in a later cell");
`endif

endmodule

`default_nettype wire

/* hdl/splitter_tree_equal_classifier_unit.sv */
// ----------------------------------------------------------------------------
// splitter_tree_equal_classifier_unit: splitter tree key classifier
// Chain of one cell per tree level; load items write splitters on their way
// down, classify items walk one node per cell and leave with a bucket.
// ----------------------------------------------------------------------------
// Usage:
// The items channel takes load items (func 0), which write the 64-bit key as
// the splitter of heap node node_index, and classify items (func 1), which
// give one bucket on the results channel. Loads give no result. Every item
// passes through all TREE_BITS cells in order, so a load only affects items
// accepted after it.
// A classify item is registered in each of the TREE_BITS cells (4 with the
// default tree) in turn before its bucket shows. Throughput is one item per
// cycle unless results stall, set by the per-level cells, one item in each.
// When results are stalled, ready on the items channel drops and the whole
// chain holds in place; the waiting bucket stays stable until taken.
// Reset clears the valid bits of the chain only. Splitter storage is not
// cleared; a node must be loaded before a key is classified against it.
// ----------------------------------------------------------------------------
`default_nettype none

module splitter_tree_equal_classifier_unit (
  input  wire logic clk,
  input  wire logic rst,
  stc_in_if.sink    items,
  stc_out_if.source results
);
  import stc_pkg::*;

  stage_t stage [TREE_BITS+1];
  logic   advance;
  logic   last_result;

  always_comb begin
    stage[0].valid      = items.valid;
    stage[0].func       = func_t'(items.func);
    stage[0].node_index = items.node_index;
    stage[0].key        = items.key;
    stage[0].node       = NODE_W'(1);
    stage[0].hit        = 1'b0;
    stage[0].bucket     = '0;
  end

  for (genvar k = 0; k < TREE_BITS; k++) begin : g_cell
    stc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .level   (LEVEL_W'(k)),
      .advance (advance),
      .cur     (stage[k]),
      .nxt     (stage[k+1])
    );
  end

  // Load items leave the last cell silently; only classify items wait.
  always_comb begin
    last_result    = stage[TREE_BITS].valid && (stage[TREE_BITS].func == FUNC_CLASSIFY);
    advance        = !last_result || results.ready;
    items.ready    = advance;
    results.valid  = last_result;
    results.bucket = stage[TREE_BITS].hit ? stage[TREE_BITS].bucket
                                          : leaf_bucket(stage[TREE_BITS].node);
  end

`ifndef ASSERT_OFF
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |-> !items.ready)
    else $error("item taken while the result was stalled");

  a_hit_odd: assert property (@(posedge clk) disable iff (rst)
    results.valid && stage[TREE_BITS].hit |-> results.bucket[0])
    else $error("equal match gave an even bucket");

  a_miss_even: assert property (@(posedge clk) disable iff (rst)
    results.valid && !stage[TREE_BITS].hit |-> !results.bucket[0])
    else $error("leaf slot gave an odd bucket");
`endif

endmodule

`default_nettype wire

/* tb/tb_splitter_tree_equal_classifier_unit.sv */
// ----------------------------------------------------------------------------
// tb_splitter_tree_equal_classifier_unit: self-checking bench for the classifier
// Loads splitter trees, classifies keys against them and compares each bucket
// with a bucket computed here from a private copy of the tree. Both channels
// idle at random, the result side holds off once for a long stretch, and the
// sender drains the block twice before it goes on.
// ----------------------------------------------------------------------------
module tb_splitter_tree_equal_classifier_unit;
  import stc_pkg::*;

  localparam int TARGET_ITEMS   = 1600;
  localparam int HOLDOFF_AT     = 500;
  localparam int HOLDOFF_CYCLES = 96;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 3 * TREE_BITS + 8;

  typedef struct {
    func_t             func;
    logic [NIDX_W-1:0] node_index;
    logic [KEY_W-1:0]  key;
    bit                drain;
  } tree_item_t;

  logic clk;
  logic rst;

  stc_in_if  items_if ();
  stc_out_if results_if ();

  splitter_tree_equal_classifier_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  // Stimulus side: items waiting to be sent and the tree as the sender sees it.
  tree_item_t        item_q[$];
  logic [KEY_W-1:0]  gen_tree [1:NUM_SPLITTERS];
  bit                drain_next;
  int                n_items;

  // Checking side: the tree as the block should hold it and the buckets owed.
  logic [KEY_W-1:0]    split_val [1:NUM_SPLITTERS];
  logic [BUCKET_W-1:0] bucket_q[$];

  tree_item_t cur_item;
  int         gap_left;
  int         send_streak;
  int         recv_streak;
  int         recv_wait;
  int         hold_left;
  int         classify_sent;
  int         results_seen;
  int         sent_now;
  int         fail_count;
  int         quiet_cycles;
  logic [BUCKET_W-1:0] want_bucket;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Walks the tree one level at a time while narrowing the range of leaf
  // slots below the current node; the middle of that range is the in-order
  // position of the node.
  function automatic logic [BUCKET_W-1:0] bucket_for(logic [KEY_W-1:0] k);
    int node;
    int lo;
    int span;
    node = 1;
    lo   = 0;
    span = NUM_SPLITTERS + 1;
    while (node <= NUM_SPLITTERS) begin
      span = span / 2;
      if (k == split_val[node]) return BUCKET_W'(2 * (lo + span) - 1);
      if (k > split_val[node]) begin
        lo   = lo + span;
        node = 2 * node + 1;
      end else begin
        node = 2 * node;
      end
    end
    return BUCKET_W'(2 * lo);
  endfunction

  // In-order position (1-based) of a heap node, from the path bits below
  // its leading one.
  function automatic int inorder_of(int n);
    int lvl;
    int lo;
    int span;
    int i;
    lvl = 0;
    while ((n >> (lvl + 1)) != 0) lvl++;
    lo   = 0;
    span = NUM_SPLITTERS + 1;
    for (i = lvl - 1; i >= 0; i--) begin
      span = span / 2;
      if (((n >> i) & 1) != 0) lo = lo + span;
    end
    return lo + span / 2;
  endfunction

  // Wait before the next item; now and then a run of back-to-back items.
  function automatic int draw_wait(inout int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      streak = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic push_item(func_t f, int n, logic [KEY_W-1:0] k);
    tree_item_t it;
    it.func       = f;
    it.node_index = NIDX_W'(n);
    it.key        = k;
    it.drain      = drain_next;
    drain_next    = 1'b0;
    item_q        = {item_q, it};
    if (f == FUNC_CLASSIFY) begin
      n_items++;
    end else if (n >= 1 && n <= NUM_SPLITTERS) begin
      gen_tree[n] = k;
      n_items++;
    end
  endtask

  // Keys that land on splitters, right beside them, or anywhere.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] s;
    s = gen_tree[$urandom_range(1, NUM_SPLITTERS)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return s;
      4:          return s + 1;
      5:          return s - 1;
      6:          return ($urandom_range(0, 1) != 0) ? '0 : '1;
      7:          return s + KEY_W'($urandom_range(0, 7)) - 4;
      default:    return rand_key();
    endcase
  endfunction

  // Loads all nodes with sorted values so that the tree is a search tree.
  // The spread ranges from full 64-bit values to a few dozen values with ties.
  task automatic load_sorted_tree();
    logic [KEY_W-1:0] vals [0:NUM_SPLITTERS-1];
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] t;
    int kind;
    int first;
    int i;
    int j;
    int n;
    kind = $urandom_range(0, 3);
    base = rand_key();
    for (i = 0; i < NUM_SPLITTERS; i++) begin
      case (kind)
        0:       vals[i] = rand_key();
        1:       vals[i] = base + KEY_W'($urandom_range(0, 40));
        2:       vals[i] = '1 - KEY_W'($urandom_range(0, 40));
        default: vals[i] = KEY_W'($urandom_range(0, 40));
      endcase
    end
    for (i = 1; i < NUM_SPLITTERS; i++) begin
      t = vals[i];
      j = i - 1;
      while (j >= 0 && vals[j] > t) begin
        vals[j + 1] = vals[j];
        j--;
      end
      vals[j + 1] = t;
    end
    first = $urandom_range(0, NUM_SPLITTERS - 1);
    for (i = 0; i < NUM_SPLITTERS; i++) begin
      n = ((first + i) % NUM_SPLITTERS) + 1;
      push_item(FUNC_LOAD, n, vals[inorder_of(n) - 1]);
    end
  endtask

  task automatic build_stimulus();
    int n;
    int r;
    bit mid_drain_done;
    mid_drain_done = 1'b0;
    drain_next     = 1'b0;
    n_items        = 0;

    // Directed part: splitter p holds p << 60, so the extreme keys fall off
    // both ends and the first and last splitters give the outer odd buckets.
    for (n = 1; n <= NUM_SPLITTERS; n++)
      push_item(FUNC_LOAD, n, KEY_W'(inorder_of(n)) << 60);
    // A load at node zero must leave the root alone.
    push_item(FUNC_LOAD, 0, 64'h8000_0000_0000_0005);
    push_item(FUNC_CLASSIFY, 0, '0);
    push_item(FUNC_CLASSIFY, 0, '1);
    push_item(FUNC_CLASSIFY, 0, 64'h1000_0000_0000_0000);
    push_item(FUNC_CLASSIFY, 0, 64'hF000_0000_0000_0000);
    push_item(FUNC_CLASSIFY, 0, 64'h8000_0000_0000_0000);
    push_item(FUNC_CLASSIFY, 0, 64'h8000_0000_0000_0001);
    push_item(FUNC_CLASSIFY, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    // The node index of a classify item has no effect.
    push_item(FUNC_CLASSIFY, 15, 64'h3000_0000_0000_0000);

    drain_next = 1'b1;
    while (n_items < TARGET_ITEMS) begin
      if (!mid_drain_done && n_items >= TARGET_ITEMS / 2) begin
        drain_next     = 1'b1;
        mid_drain_done = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) load_sorted_tree();
      repeat ($urandom_range(10, 60)) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          // A stray load breaks the search order of the tree.
          push_item(FUNC_LOAD, $urandom_range(1, NUM_SPLITTERS),
                    ($urandom_range(0, 1) != 0) ? rand_key() : pick_key());
        end else if (r == 1) begin
          push_item(FUNC_LOAD, 0, rand_key());
        end else begin
          push_item(FUNC_CLASSIFY, $urandom_range(0, 15), pick_key());
        end
      end
    end
  endtask

  // Sender
  always @(posedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
      gap_left       <= 0;
      classify_sent  <= 0;
    end else begin
      sent_now = classify_sent;
      if (items_if.valid && items_if.ready) begin
        if (cur_item.func == FUNC_CLASSIFY) begin
          bucket_q = {bucket_q, bucket_for(cur_item.key)};
          sent_now = sent_now + 1;
        end else if (cur_item.node_index >= 1 && cur_item.node_index <= NUM_SPLITTERS) begin
          split_val[cur_item.node_index] = cur_item.key;
        end
      end
      classify_sent <= sent_now;

      if (items_if.valid && !items_if.ready) begin
        // Keep offering the same item.
      end else if (gap_left > 0) begin
        items_if.valid <= 1'b0;
        gap_left       <= gap_left - 1;
      end else if (item_q.size() > 0 && !(item_q[0].drain && sent_now != results_seen)) begin
        cur_item = item_q.pop_front();
        items_if.valid      <= 1'b1;
        items_if.func       <= cur_item.func;
        items_if.node_index <= cur_item.node_index;
        items_if.key        <= cur_item.key;
        gap_left            <= draw_wait(send_streak);
      end else begin
        items_if.valid <= 1'b0;
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      hold_left        <= 0;
      results_seen     <= 0;
    end else if (results_if.valid && results_if.ready) begin
      if (bucket_q.size() == 0) begin
        if (fail_count < 10)
          $display("bucket %0d arrived with no classify item outstanding",
                   results_if.bucket);
        fail_count++;
      end else begin
        want_bucket = bucket_q.pop_front();
        if (results_if.bucket !== want_bucket) begin
          if (fail_count < 10)
            $display("bucket mismatch on result %0d: expected %0d, got %0d",
                     results_seen, want_bucket, results_if.bucket);
          fail_count++;
        end
      end
      results_seen <= results_seen + 1;
      // One long hold-off lets the block fill and push back on its input.
      if (results_seen + 1 == HOLDOFF_AT) begin
        recv_wait = HOLDOFF_CYCLES;
      end else begin
        recv_wait = draw_wait(recv_streak);
      end
      hold_left        <= recv_wait;
      results_if.ready <= (recv_wait == 0);
    end else if (hold_left > 0) begin
      hold_left        <= hold_left - 1;
      results_if.ready <= (hold_left == 1);
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted item on either channel.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((items_if.valid && items_if.ready) ||
                 (results_if.valid && results_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no item moved for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                 = 1'b1;
    items_if.valid      = 1'b0;
    items_if.func       = FUNC_LOAD;
    items_if.node_index = '0;
    items_if.key        = '0;
    results_if.ready    = 1'b0;
    fail_count          = 0;
    send_streak         = 0;
    recv_streak         = 0;
    build_stimulus();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (item_q.size() != 0 || items_if.valid || classify_sent != results_seen)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (bucket_q.size() != 0)
      $display("%0d buckets never arrived", bucket_q.size());
    if (fail_count == 0 && bucket_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/stc_pkg.sv
hdl/stc_in_if.sv
hdl/stc_out_if.sv
hdl/stc_cell.sv
hdl/splitter_tree_equal_classifier_unit.sv
tb/tb_splitter_tree_equal_classifier_unit.sv
